// ===== hw/rtl/bal_pkg.sv =====
// Shared constants and types for the bounded array list unit.
`timescale 1ns / 1ps

package bal_pkg;

	localparam int CAPACITY = 8;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 4;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int DATA_W   = 32;
	localparam int STAT_W   = 2;
	localparam int FOUND_W  = 3;
	localparam int ECNT_W   = 4;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_DELETE = 2'd1;
	localparam cmd_t CMD_FIND   = 2'd2;
	localparam cmd_t CMD_NOP    = 2'd3;

	typedef logic [STAT_W-1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_FULL     = 2'd1;
	localparam status_t ST_BADPOS   = 2'd2;
	localparam status_t ST_NOTFOUND = 2'd3;

	// per-cell move control
	typedef struct packed {
		logic load;
		logic take_left;
		logic take_right;
	} cell_ctl_t;

	typedef struct packed {
		status_t             status;
		logic [FOUND_W-1:0]  found_at;
		logic [ECNT_W-1:0]   entry_count;
	} result_t;

endpackage

// ===== hw/rtl/bal_cell.sv =====
// One list cell: holds an entry, shifts to/from neighbors, compares against the key.
`timescale 1ns / 1ps

module bal_cell (
	input  logic                       clk,
	input  bal_pkg::cell_ctl_t         ctl,
	input  logic signed [31:0]         value,
	input  logic signed [31:0]         left_data,
	input  logic signed [31:0]         right_data,
	output logic signed [31:0]         data_q,
	output logic                       match
);
	import bal_pkg::*;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= value;
		end else if (ctl.take_left) begin
			data_q <= left_data;
		end else if (ctl.take_right) begin
			data_q <= right_data;
		end
	end

	assign match = (data_q == value);

endmodule

// ===== hw/rtl/bal_out_buf.sv =====
// Output register with a skid slot so a new transaction is taken while a result waits.
`timescale 1ns / 1ps

module bal_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  bal_pkg::result_t  res,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output bal_pkg::result_t  out_res
);
	import bal_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= res_valid;
				end
			end else if (res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// ===== hw/rtl/bounded_array_list_unit.sv =====
// Top level: bounded ordered list built as a row of shifting compare cells.
`timescale 1ns / 1ps
// Each result is registered when accepted, in the skid slot if the output is stalled.
// Throughput: one transaction per cycle; cells and count update at the accepting edge.
//   in_stall is high only while a result waits in the skid slot behind a stalled output.
// Reset: arst_n clears the entry count and the output/skid valid flags; cell contents
//   are left as they are and are only read below the count.
module bounded_array_list_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] value,
	input  logic [3:0]         position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [2:0]         found_at,
	output logic [3:0]         entry_count
);
	import bal_pkg::*;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	logic               in_acc;
	logic               buf_full;
	logic [CMP_W-1:0]   pos_x;
	logic [CMP_W-1:0]   cnt_x;
	logic               is_full;
	logic               ins_ok;
	logic               del_ok;
	logic               hit;
	logic [IDX_W-1:0]   hit_idx;
	result_t            res;
	result_t            out_res;

	logic signed [31:0] cell_data [CAPACITY];
	logic               cell_match [CAPACITY];
	cell_ctl_t          cell_ctl [CAPACITY];

	// Input is held back only when the skid slot is already occupied.
	assign in_stall = buf_full;
	assign in_acc   = in_valid && !in_stall;

	assign pos_x   = CMP_W'(position);
	assign cnt_x   = CMP_W'(count_q);
	assign is_full = (count_q >= CNT_W'(CAPACITY));
	// full is checked before the position range
	assign ins_ok  = (command == CMD_INSERT) && !is_full && (pos_x <= cnt_x);
	assign del_ok  = (command == CMD_DELETE) && (pos_x < cnt_x);

	// Cell i loads the key at the insert point, takes its left neighbor above it
	// on insert, and takes its right neighbor at and above the point on delete.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_d;
		logic signed [31:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = value;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end

		assign cell_ctl[i].load       = in_acc && ins_ok && (pos_x == CMP_W'(i));
		assign cell_ctl[i].take_left  = in_acc && ins_ok && (pos_x <  CMP_W'(i));
		assign cell_ctl[i].take_right = in_acc && del_ok && (pos_x <= CMP_W'(i));

		bal_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.value      (value),
			.left_data  (left_d),
			.right_data (right_d),
			.data_q     (cell_data[i]),
			.match      (cell_match[i])
		);
	end

	// Lowest matching occupied cell; scan from the top so the lowest wins.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_match[i] && (CNT_W'(i) < count_q)) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		count_nxt       = count_q;
		res.status      = ST_OK;
		res.found_at    = '0;
		unique case (command)
			CMD_INSERT: begin
				if (is_full) begin
					res.status = ST_FULL;
				end else if (!ins_ok) begin
					res.status = ST_BADPOS;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (!del_ok) begin
					res.status = ST_BADPOS;
				end else begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			CMD_FIND: begin
				if (hit) begin
					res.found_at = FOUND_W'(hit_idx);
				end else begin
					res.status = ST_NOTFOUND;
				end
			end
			default: begin
				// CMD_NOP: no operation
			end
		endcase
		res.entry_count = ECNT_W'(count_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_acc) begin
			count_q <= count_nxt;
		end
	end

	bal_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (in_acc),
		.res       (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign status      = out_res.status;
	assign found_at    = out_res.found_at;
	assign entry_count = out_res.entry_count;

endmodule
